### hdl/ckg_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ckg_pkg
// Shared types, constants and helpers for the ChaCha20 keystream generator.
// ============================================================================
package ckg_pkg;

    localparam int WORD_W      = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int BYTES_W     = 7;
    localparam int VALID_W     = 3;
    localparam int STATE_WORDS = 16;
    localparam int WIDX_W      = 4;

    localparam logic [BYTES_W-1:0] BLOCK_BYTES = 7'd64;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [BYTES_W-1:0]   bytes_t;
    typedef logic [VALID_W-1:0]   valid_cnt_t;
    typedef logic [WIDX_W-1:0]    widx_t;

    // Register indexes of the configuration port
    localparam cfg_idx_t CFG_KEY_01    = 3'd0;
    localparam cfg_idx_t CFG_KEY_23    = 3'd1;
    localparam cfg_idx_t CFG_KEY_45    = 3'd2;
    localparam cfg_idx_t CFG_KEY_67    = 3'd3;
    localparam cfg_idx_t CFG_NONCE_01  = 3'd4;
    localparam cfg_idx_t CFG_NONCE_2   = 3'd5;
    localparam cfg_idx_t CFG_CTR_START = 3'd6;

    localparam word_t SIGMA_0 = 32'h6170_7865;
    localparam word_t SIGMA_1 = 32'h3320_646e;
    localparam word_t SIGMA_2 = 32'h7962_2d32;
    localparam word_t SIGMA_3 = 32'h6b20_6574;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    // One half of a quarter round: two add/xor/rotate pairs.
    function automatic quad_t qr_half(input quad_t q, input logic second);
        quad_t r;
        word_t x;
        word_t y;
        r   = q;
        r.a = q.a + q.b;
        x   = q.d ^ r.a;
        r.d = second ? {x[23:0], x[31:24]} : {x[15:0], x[31:16]};
        r.c = q.c + r.d;
        y   = q.b ^ r.c;
        r.b = second ? {y[24:0], y[31:25]} : {y[19:0], y[31:20]};
        return r;
    endfunction

endpackage

### hdl/ckg_intf.sv
`timescale 1ns / 1ps
// ============================================================================
// ckg request and keystream channels
// Valid/ready channel interfaces for block requests and keystream words.
// ============================================================================
interface ckg_req_if;
    logic                  valid;
    logic                  ready;
    ckg_pkg::bytes_t       bytes_wanted;
    logic                  reload_counter;

    modport source (output valid, output bytes_wanted, output reload_counter, input ready);
    modport sink   (input valid, input bytes_wanted, input reload_counter, output ready);
endinterface

interface ckg_ks_if;
    logic                  valid;
    logic                  ready;
    ckg_pkg::word_t        keystream_word;
    ckg_pkg::valid_cnt_t   bytes_valid;
    logic                  last_word;

    modport source (output valid, output keystream_word, output bytes_valid,
                    output last_word, input ready);
    modport sink   (input valid, input keystream_word, input bytes_valid,
                    input last_word, output ready);
endinterface

### hdl/chacha20_keystream_generator_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// chacha20_keystream_generator_unit
// ChaCha20 block function with a shared four-lane half-quarter-round unit.
// ============================================================================
// One request beat produces one 64-byte block: the cycle that takes the beat
// also loads the 16-word state, then DOUBLE_ROUNDS double rounds run on the
// shared four-lane half-quarter-round unit, each column or diagonal pass in
// two halves; then one word per cycle, ceil(bytes/4) words in all, while the
// keystream sink does not stall, adds the input state back in and presents
// the word. Requests above 64 bytes are treated as 64; a zero-byte request
// still advances the counter. Configuration is to be written only while the
// unit is idle; the unit itself does not enforce this.
module chacha20_keystream_generator_unit #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  ckg_pkg::cfg_idx_t   cfg_index,
    input  ckg_pkg::cfg_data_t  cfg_data,
    ckg_req_if.sink             req,
    ckg_ks_if.source            ks
);
    import ckg_pkg::*;

    localparam int RIDX_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
    localparam logic [RIDX_W-1:0] LAST_ROUND = RIDX_W'(DOUBLE_ROUNDS - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    cfg_data_t         key01_reg, key23_reg, key45_reg, key67_reg, nonce01_reg;
    word_t             nonce2_reg, ctr_start_reg;
    word_t             block_counter_reg, block_counter_next;
    word_t             cur_ctr_reg, cur_ctr_next;
    word_t             work_reg [STATE_WORDS];
    word_t             work_next [STATE_WORDS];
    word_t             init_words [STATE_WORDS];
    word_t             ctr_sel;
    logic [RIDX_W-1:0] round_index_reg, round_index_next;
    logic              half_reg, half_next;
    logic              diag_reg, diag_next;
    bytes_t            bytes_reg, bytes_next;
    widx_t             word_idx_reg, word_idx_next;
    logic              out_valid_reg, out_valid_next;
    word_t             out_word_reg, out_word_next;
    valid_cnt_t        out_cnt_reg, out_cnt_next;
    logic              out_last_reg, out_last_next;

    logic              req_fire;
    logic              emit_go;
    bytes_t            remaining;
    valid_cnt_t        emit_cnt;
    word_t             emit_sum;
    word_t             emit_mask;
    logic              emit_last;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign ks.valid          = out_valid_reg;
    assign ks.keystream_word = out_word_reg;
    assign ks.bytes_valid    = out_cnt_reg;
    assign ks.last_word      = out_last_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key01_reg     <= '0;
            key23_reg     <= '0;
            key45_reg     <= '0;
            key67_reg     <= '0;
            nonce01_reg   <= '0;
            nonce2_reg    <= '0;
            ctr_start_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_01:    key01_reg     <= cfg_data;
                CFG_KEY_23:    key23_reg     <= cfg_data;
                CFG_KEY_45:    key45_reg     <= cfg_data;
                CFG_KEY_67:    key67_reg     <= cfg_data;
                CFG_NONCE_01:  nonce01_reg   <= cfg_data;
                CFG_NONCE_2:   nonce2_reg    <= cfg_data[WORD_W-1:0];
                CFG_CTR_START: ctr_start_reg <= cfg_data[WORD_W-1:0];
                default:       ;
            endcase
        end
    end

    // Input state; while idle it carries the counter the next block will use
    always_comb
    begin
        if (state_reg == ST_IDLE)
            ctr_sel = req.reload_counter ? ctr_start_reg : block_counter_reg;
        else
            ctr_sel = cur_ctr_reg;
        init_words[0]  = SIGMA_0;
        init_words[1]  = SIGMA_1;
        init_words[2]  = SIGMA_2;
        init_words[3]  = SIGMA_3;
        init_words[4]  = key01_reg[31:0];
        init_words[5]  = key01_reg[63:32];
        init_words[6]  = key23_reg[31:0];
        init_words[7]  = key23_reg[63:32];
        init_words[8]  = key45_reg[31:0];
        init_words[9]  = key45_reg[63:32];
        init_words[10] = key67_reg[31:0];
        init_words[11] = key67_reg[63:32];
        init_words[12] = ctr_sel;
        init_words[13] = nonce01_reg[31:0];
        init_words[14] = nonce01_reg[63:32];
        init_words[15] = nonce2_reg;
    end

    // Output word: feed-forward add, byte count and mask
    always_comb
    begin
        remaining = bytes_reg - {1'b0, word_idx_reg, 2'b00};
        emit_last = (remaining <= 7'd4);
        emit_cnt  = emit_last ? remaining[VALID_W-1:0] : 3'd4;
        emit_sum  = work_reg[word_idx_reg] + init_words[word_idx_reg];
        unique case (emit_cnt)
            3'd1:    emit_mask = 32'h0000_00ff;
            3'd2:    emit_mask = 32'h0000_ffff;
            3'd3:    emit_mask = 32'h00ff_ffff;
            default: emit_mask = 32'hffff_ffff;
        endcase
    end

    assign emit_go = (state_reg == ST_EMIT) && (!out_valid_reg || ks.ready);

    // Sequencer and shared round unit
    always_comb
    begin
        quad_t q;
        quad_t r;
        widx_t ia, ib, ic, id;
        logic [1:0] lb, lc, ld;

        q  = '0;
        r  = '0;
        ia = '0;
        ib = '0;
        ic = '0;
        id = '0;
        lb = '0;
        lc = '0;
        ld = '0;

        state_next         = state_reg;
        block_counter_next = block_counter_reg;
        cur_ctr_next       = cur_ctr_reg;
        round_index_next   = round_index_reg;
        half_next          = half_reg;
        diag_next          = diag_reg;
        bytes_next         = bytes_reg;
        word_idx_next      = word_idx_reg;
        out_valid_next     = out_valid_reg && !ks.ready;
        out_word_next      = out_word_reg;
        out_cnt_next       = out_cnt_reg;
        out_last_next      = out_last_reg;
        work_next          = work_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    bytes_next         = (req.bytes_wanted > BLOCK_BYTES) ?
                                         BLOCK_BYTES : req.bytes_wanted;
                    cur_ctr_next       = ctr_sel;
                    block_counter_next = ctr_sel + 32'd1;
                    round_index_next   = '0;
                    half_next          = 1'b0;
                    diag_next          = 1'b0;
                    word_idx_next      = '0;
                    work_next          = init_words;
                    state_next         = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    lb = diag_reg ? 2'(i + 1) : 2'(i);
                    lc = diag_reg ? 2'(i + 2) : 2'(i);
                    ld = diag_reg ? 2'(i + 3) : 2'(i);
                    ia = {2'b00, 2'(i)};
                    ib = {2'b01, lb};
                    ic = {2'b10, lc};
                    id = {2'b11, ld};
                    q  = '{a: work_reg[ia], b: work_reg[ib],
                           c: work_reg[ic], d: work_reg[id]};
                    r  = qr_half(q, half_reg);
                    work_next[ia] = r.a;
                    work_next[ib] = r.b;
                    work_next[ic] = r.c;
                    work_next[id] = r.d;
                end
                half_next = !half_reg;
                if (half_reg)
                begin
                    diag_next = !diag_reg;
                    if (diag_reg)
                    begin
                        if (round_index_reg == LAST_ROUND)
                        begin
                            round_index_next = '0;
                            state_next       = (bytes_reg == '0) ? ST_IDLE : ST_EMIT;
                        end
                        else
                        begin
                            round_index_next = round_index_reg + 1'b1;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = emit_sum & emit_mask;
                    out_cnt_next   = emit_cnt;
                    out_last_next  = emit_last;
                    word_idx_next  = word_idx_reg + 1'b1;
                    if (emit_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            block_counter_reg <= '0;
            round_index_reg   <= '0;
            half_reg          <= 1'b0;
            diag_reg          <= 1'b0;
            word_idx_reg      <= '0;
            bytes_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            block_counter_reg <= block_counter_next;
            round_index_reg   <= round_index_next;
            half_reg          <= half_next;
            diag_reg          <= diag_next;
            word_idx_reg      <= word_idx_next;
            bytes_reg         <= bytes_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        cur_ctr_reg  <= cur_ctr_next;
        work_reg     <= work_next;
        out_word_reg <= out_word_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

endmodule

### test/chacha20_keystream_generator_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// chacha20_keystream_generator_unit_tb
// Self-checking bench for the ChaCha20 keystream unit. A directed table
// covers the zero-key and RFC 8439 block vectors, partial words, empty
// requests, oversized requests, reloads and the counter wrap. Random
// requests then run under several key/nonce/counter settings with random
// stalls on both channels. Every keystream beat is checked against a
// block-function model kept in the bench.
// ============================================================================
module chacha20_keystream_generator_unit_tb;
    import ckg_pkg::*;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int SETTLE_CYCLES = 4 * DOUBLE_ROUNDS + 40;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 68;
    localparam int CALM_ITEMS    = 40;
    localparam int DIR_ROWS      = 24;
    localparam longint LIMIT_NS  = 64'd20_000_000;

    localparam cfg_idx_t CFG_UNUSED_IDX = 3'd7;

    typedef enum logic [1:0] {SET_KEEP, SET_RFC, SET_WRAP} setting_t;

    typedef struct packed {
        setting_t cfg_step;
        bytes_t   want;
        logic     reload;
        logic     pin;
        word_t    pin_word;
    } stim_row_t;

    typedef struct packed {
        word_t      word;
        valid_cnt_t nbytes;
        logic       last;
    } ks_beat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    cfg_data_t cfg_data;

    ckg_req_if req_ch ();
    ckg_ks_if  ks_ch ();

    chacha20_keystream_generator_unit #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .ks       (ks_ch)
    );

    // Bench copy of the unit's registers and block counter
    cfg_data_t cfg_copy [7];
    word_t     next_ctr;
    ks_beat_t  ks_pending [$];

    logic calm;
    int   err_count;
    int   reqs_sent;
    int   empty_reqs;
    int   reload_reqs;
    int   words_checked;
    int   settings_used;
    int   wraps_seen;

    // Pinned first words: all-zero key/nonce at counter 0 starts 76 b8 e0 ad,
    // the RFC 8439 block example at counter 1 starts 10 f1 e7 e4.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{SET_KEEP, 7'd64,  1'b0, 1'b1, 32'hade0_b876},
        '{SET_KEEP, 7'd1,   1'b1, 1'b1, 32'h0000_0076},
        '{SET_KEEP, 7'd2,   1'b1, 1'b1, 32'h0000_b876},
        '{SET_KEEP, 7'd3,   1'b1, 1'b1, 32'h00e0_b876},
        '{SET_KEEP, 7'd4,   1'b1, 1'b1, 32'hade0_b876},
        '{SET_KEEP, 7'd127, 1'b1, 1'b1, 32'hade0_b876},
        '{SET_KEEP, 7'd0,   1'b0, 1'b0, 32'h0},
        '{SET_KEEP, 7'd5,   1'b0, 1'b0, 32'h0},
        '{SET_KEEP, 7'd63,  1'b0, 1'b0, 32'h0},
        '{SET_KEEP, 7'd65,  1'b0, 1'b0, 32'h0},
        '{SET_KEEP, 7'd96,  1'b0, 1'b0, 32'h0},
        '{SET_KEEP, 7'd0,   1'b1, 1'b0, 32'h0},
        '{SET_KEEP, 7'd61,  1'b0, 1'b0, 32'h0},
        '{SET_RFC,  7'd64,  1'b1, 1'b1, 32'he4e7_f110},
        '{SET_KEEP, 7'd64,  1'b0, 1'b0, 32'h0},
        '{SET_KEEP, 7'd7,   1'b0, 1'b0, 32'h0},
        '{SET_KEEP, 7'd0,   1'b0, 1'b0, 32'h0},
        '{SET_KEEP, 7'd33,  1'b0, 1'b0, 32'h0},
        '{SET_WRAP, 7'd64,  1'b1, 1'b0, 32'h0},
        '{SET_KEEP, 7'd64,  1'b0, 1'b0, 32'h0},
        '{SET_KEEP, 7'd2,   1'b0, 1'b0, 32'h0},
        '{SET_KEEP, 7'd127, 1'b1, 1'b0, 32'h0},
        '{SET_KEEP, 7'd0,   1'b0, 1'b0, 32'h0},
        '{SET_KEEP, 7'd9,   1'b0, 1'b0, 32'h0}
    };

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic word_t rotl(input word_t v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [127:0] quarter_mix(input word_t a, input word_t b,
                                                 input word_t c, input word_t d);
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        return {a, b, c, d};
    endfunction

    // Full 64-byte block for the given counter, word i in bits 32*i+31..32*i
    function automatic logic [511:0] chacha_block(input word_t ctr);
        word_t init [16];
        word_t x [16];
        logic [511:0] ks;
        init[0] = SIGMA_0;
        init[1] = SIGMA_1;
        init[2] = SIGMA_2;
        init[3] = SIGMA_3;
        for (int i = 0; i < 4; i++)
        begin
            init[4 + 2 * i] = cfg_copy[i][31:0];
            init[5 + 2 * i] = cfg_copy[i][63:32];
        end
        init[12] = ctr;
        init[13] = cfg_copy[CFG_NONCE_01][31:0];
        init[14] = cfg_copy[CFG_NONCE_01][63:32];
        init[15] = cfg_copy[CFG_NONCE_2][31:0];
        for (int i = 0; i < 16; i++)
            x[i] = init[i];
        for (int r = 0; r < DOUBLE_ROUNDS; r++)
        begin
            {x[0], x[4], x[8],  x[12]} = quarter_mix(x[0], x[4], x[8],  x[12]);
            {x[1], x[5], x[9],  x[13]} = quarter_mix(x[1], x[5], x[9],  x[13]);
            {x[2], x[6], x[10], x[14]} = quarter_mix(x[2], x[6], x[10], x[14]);
            {x[3], x[7], x[11], x[15]} = quarter_mix(x[3], x[7], x[11], x[15]);
            {x[0], x[5], x[10], x[15]} = quarter_mix(x[0], x[5], x[10], x[15]);
            {x[1], x[6], x[11], x[12]} = quarter_mix(x[1], x[6], x[11], x[12]);
            {x[2], x[7], x[8],  x[13]} = quarter_mix(x[2], x[7], x[8],  x[13]);
            {x[3], x[4], x[9],  x[14]} = quarter_mix(x[3], x[4], x[9],  x[14]);
        end
        for (int i = 0; i < 16; i++)
            ks[32 * i +: 32] = x[i] + init[i];
        return ks;
    endfunction

    // Queue the keystream beats one accepted request causes
    task automatic predict_block(input bytes_t want, input logic reload,
                                 input logic pin, input word_t pin_word);
        int n;
        int nwords;
        int left;
        logic [511:0] ks;
        ks_beat_t beat;
        n = (want > BLOCK_BYTES) ? 64 : int'(want);
        if (reload)
            next_ctr = cfg_copy[CFG_CTR_START][31:0];
        if (next_ctr == 32'hFFFF_FFFF)
            wraps_seen++;
        ks = chacha_block(next_ctr);
        nwords = (n + 3) / 4;
        for (int k = 0; k < nwords; k++)
        begin
            left = n - 4 * k;
            beat.nbytes = (left > 4) ? 3'd4 : valid_cnt_t'(left);
            beat.word = ks[32 * k +: 32];
            if (left < 4)
                beat.word = beat.word & ((32'd1 << (8 * left)) - 32'd1);
            if (k == 0 && pin)
                beat.word = pin_word;
            beat.last = (k + 1 == nwords);
            ks_pending.push_back(beat);
        end
        next_ctr = next_ctr + 32'd1;
    endtask

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_beat();
        ks_beat_t exp_beat;
        if (ks_pending.size() == 0)
        begin
            report_mismatch("keystream beat with nothing pending", ks_ch.keystream_word, 32'h0);
            return;
        end
        exp_beat = ks_pending.pop_front();
        words_checked++;
        if (ks_ch.keystream_word !== exp_beat.word)
            report_mismatch("keystream_word", ks_ch.keystream_word, exp_beat.word);
        if (ks_ch.bytes_valid !== exp_beat.nbytes)
            report_mismatch("bytes_valid", word_t'(ks_ch.bytes_valid), word_t'(exp_beat.nbytes));
        if (ks_ch.last_word !== exp_beat.last)
            report_mismatch("last_word", word_t'(ks_ch.last_word), word_t'(exp_beat.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && ks_ch.valid === 1'b1 && ks_ch.ready === 1'b1)
            check_beat();
    end

    // Keystream sink: random stall bursts until the calm tail of the run
    initial
    begin
        int stall_left;
        stall_left = 0;
        ks_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
                stall_left = 0;
            if (stall_left > 0)
            begin
                ks_ch.ready = 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                ks_ch.ready = 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end
            else
                ks_ch.ready = 1'b1;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx <= CFG_CTR_START)
            cfg_copy[idx] = (idx >= CFG_NONCE_2) ? (val & 64'hFFFF_FFFF) : val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_req(input bytes_t want, input logic reload,
                            input logic pin, input word_t pin_word);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.bytes_wanted = want;
        req_ch.reload_counter = reload;
        req_ch.valid = 1'b1;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predict_block(want, reload, pin, pin_word);
        reqs_sent++;
        if (want == 7'd0)
            empty_reqs++;
        if (reload)
            reload_reqs++;
    endtask

    // Drop valid and hold until every queued beat has come back
    task automatic hold_until_empty();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (ks_pending.size() != 0)
            @(posedge clk);
    endtask

    // Empty requests leave no beat behind, so give the unit time to finish
    task automatic quiesce();
        hold_until_empty();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_setting(input setting_t which);
        settings_used++;
        if (which == SET_RFC)
        begin
            write_reg(CFG_KEY_01,    64'h0706_0504_0302_0100);
            write_reg(CFG_KEY_23,    64'h0f0e_0d0c_0b0a_0908);
            write_reg(CFG_KEY_45,    64'h1716_1514_1312_1110);
            write_reg(CFG_KEY_67,    64'h1f1e_1d1c_1b1a_1918);
            write_reg(CFG_NONCE_01,  64'h4a00_0000_0900_0000);
            write_reg(CFG_NONCE_2,   64'ha5a5_a5a5_0000_0000);
            write_reg(CFG_CTR_START, 64'h5a5a_5a5a_0000_0001);
        end
        else
        begin
            write_reg(CFG_CTR_START, {$urandom, 32'hFFFF_FFFF});
            write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
        end
    endtask

    // Random settings; the first two phases take the all-ones and all-zeros extremes
    task automatic load_phase_regs(input int phase);
        cfg_data_t val;
        settings_used++;
        for (int i = 0; i <= int'(CFG_CTR_START); i++)
        begin
            if (phase == 0)
                val = '1;
            else if (phase == 1)
                val = '0;
            else
                val = {$urandom, $urandom};
            if (i == int'(CFG_CTR_START) && phase > 1 && $urandom_range(0, 1) == 1)
                val[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 6);
            write_reg(cfg_idx_t'(i), val);
        end
        write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
    endtask

    initial
    begin
        bytes_t want;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.bytes_wanted = '0;
        req_ch.reload_counter = 1'b0;
        for (int i = 0; i < 7; i++)
            cfg_copy[i] = '0;
        next_ctr = '0;
        calm = 1'b0;
        err_count = 0;
        reqs_sent = 0;
        empty_reqs = 0;
        reload_reqs = 0;
        words_checked = 0;
        settings_used = 1;
        wraps_seen = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].cfg_step != SET_KEEP)
            begin
                quiesce();
                load_setting(dir_rows[r].cfg_step);
            end
            send_req(dir_rows[r].want, dir_rows[r].reload,
                     dir_rows[r].pin, dir_rows[r].pin_word);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            quiesce();
            load_phase_regs(p);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == NUM_PHASES - 1 && k >= PHASE_ITEMS - CALM_ITEMS)
                    calm = 1'b1;
                if (p == 2 && k == PHASE_ITEMS / 2)
                    hold_until_empty();
                case ($urandom_range(0, 15))
                    0:       want = 7'd0;
                    1:       want = BLOCK_BYTES;
                    2:       want = bytes_t'($urandom_range(65, 127));
                    3:       want = bytes_t'($urandom_range(1, 3));
                    default: want = bytes_t'($urandom_range(1, 64));
                endcase
                send_req(want, $urandom_range(0, 7) == 0, 1'b0, 32'h0);
            end
        end

        quiesce();
        $display("Ran %0d requests (%0d empty, %0d with reload) under %0d register settings,",
                 reqs_sent, empty_reqs, reload_reqs, settings_used);
        $display("checked %0d keystream words, %0d blocks at counter 0xFFFFFFFF.",
                 words_checked, wraps_seen);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("Timed out with %0d keystream words pending", ks_pending.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
hdl/ckg_pkg.sv
hdl/ckg_intf.sv
hdl/chacha20_keystream_generator_unit.sv
test/chacha20_keystream_generator_unit_tb.sv
